// ===== sv/bta_pkg.sv =====
package bta_pkg;

  localparam logic [1:0] TAG_USED  = 2'b01;
  localparam logic [1:0] TAG_FOOT  = 2'b10;
  localparam logic [1:0] TAG_FREE  = 2'b00;

  localparam logic ACT_ALLOC = 1'b0;
  localparam logic ACT_FREE  = 1'b1;

  localparam logic [1:0] STAT_DONE    = 2'd0;
  localparam logic [1:0] STAT_NO_ROOM = 2'd1;
  localparam logic [1:0] STAT_BAD_PTR = 2'd2;

endpackage

// ===== sv/bta_ram.sv =====
module bta_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== sv/boundary_tag_heap_allocator_unit.sv =====
// channel   dir  word                                            handshake
// s_axis    in   action, request_bytes, data_offset              tvalid/tready
// m_axis    out  status, result_offset                           tvalid/tready
//
// one request at a time; the tag store is a single ram with a registered read
// allocate: walks blocks (S_ALK, S_AWT, S_AEV), then splits (S_AS1..S_AS4) or grows the heap
// free: follows a chain of dependent tag reads (header, footer, next, previous)
// after reset a clearing pass over all ARENA_BYTES / WORD_BYTES tag words runs first
// a finished result waits in the output register; the next request is taken meanwhile
module boundary_tag_heap_allocator_unit #(
  parameter int WORD_BYTES  = 8,
  parameter int PAGE_BYTES  = 4096,
  parameter int ARENA_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [39:0] s_axis_tdata,  // action, request_bytes, data_offset
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata   // status, result_offset
);

  import bta_pkg::*;

  localparam int AR_LOG = $clog2(ARENA_BYTES);
  localparam int AD_W   = ((AR_LOG > 17) ? AR_LOG : 17) + 2;
  localparam int TAG_W  = AR_LOG + 1;
  localparam int DEPTH  = ARENA_BYTES / WORD_BYTES;
  localparam int AW     = $clog2(DEPTH);
  localparam int WB_SH  = $clog2(WORD_BYTES);
  localparam int PG_SH  = $clog2(PAGE_BYTES);
  localparam logic [AD_W-1:0] WB    = AD_W'(WORD_BYTES);
  localparam logic [AD_W-1:0] TWO   = AD_W'(2 * WORD_BYTES);
  localparam logic [AD_W-1:0] PAGE  = AD_W'(PAGE_BYTES);
  localparam logic [AD_W-1:0] ARENA = AD_W'(ARENA_BYTES);

  localparam logic [4:0] S_CLR  = 5'd0,  S_INI0 = 5'd1,  S_INI1 = 5'd2,  S_IDLE = 5'd3;
  localparam logic [4:0] S_STRT = 5'd4,  S_ALK  = 5'd5,  S_AWT  = 5'd6,  S_AEV  = 5'd7;
  localparam logic [4:0] S_AS1  = 5'd8,  S_AS2  = 5'd9,  S_AS3  = 5'd10, S_AS4  = 5'd11;
  localparam logic [4:0] S_AGF0 = 5'd12, S_AGF1 = 5'd13, S_AGU0 = 5'd14, S_AGU1 = 5'd15;
  localparam logic [4:0] S_FH0  = 5'd16, S_FH1  = 5'd17, S_FF0  = 5'd18, S_FF1  = 5'd19;
  localparam logic [4:0] S_FN0  = 5'd20, S_FN1  = 5'd21, S_FP   = 5'd22, S_FQ0  = 5'd23;
  localparam logic [4:0] S_FQ1  = 5'd24, S_FR0  = 5'd25, S_FR1  = 5'd26, S_FW0  = 5'd27;
  localparam logic [4:0] S_FW1  = 5'd28, S_DONE = 5'd29;

  logic [4:0]      state;
  logic [AW-1:0]   clr_cnt;
  logic [AD_W-1:0] heap_mark, blk, ptr, bytes, grow, total, tcur;
  logic            act;
  logic [15:0]     req, off;
  logic [1:0]      stat;
  logic [15:0]     res;
  logic [1:0]      out_status;
  logic [15:0]     out_offset;

  logic            we;
  logic [AD_W-1:0] waddr;
  logic [TAG_W-1:0] wdata, rdata;

  function automatic logic [TAG_W-1:0] mk_tag(input logic [AD_W-1:0] sz, input logic [1:0] fl);
    mk_tag = {sz[TAG_W-1:2], fl};
  endfunction

  bta_ram #(.WIDTH(TAG_W), .DEPTH(DEPTH)) u_tags (
    .clk   (clk),
    .we    (we),
    .waddr ((state == S_CLR) ? clr_cnt : waddr[WB_SH +: AW]),
    .wdata (wdata),
    .raddr (ptr[WB_SH +: AW]),
    .rdata (rdata)
  );

  logic [AD_W-1:0] rsz, rnd, nxt, hdr, pg;
  logic            rused, rfoot;
  assign rsz   = {{(AD_W-TAG_W){1'b0}}, rdata[TAG_W-1:2], 2'b00};
  assign rused = rdata[0];
  assign rfoot = rdata[1];
  assign nxt   = blk + TWO + rsz;
  assign rnd   = ({{(AD_W-16){1'b0}}, req} + WB - 1'b1) & ~(WB - 1'b1);
  assign pg    = ((rnd + PAGE - 1'b1) >> PG_SH) << PG_SH;
  assign hdr   = {{(AD_W-16){1'b0}}, off} - WB;

  assign s_axis_tready = (state == S_IDLE);
  assign m_axis_tdata  = {6'b0, out_offset, out_status};

  always_comb begin
    we    = 1'b0;
    waddr = '0;
    wdata = '0;
    case (state)
      S_CLR:  we = 1'b1;
      S_INI0: begin we = 1'b1; waddr = '0; wdata = mk_tag(PAGE - TWO, TAG_FREE); end
      S_INI1: begin we = 1'b1; waddr = PAGE - WB; wdata = mk_tag(PAGE - TWO, TAG_FOOT); end
      S_AS1:  begin we = 1'b1; waddr = blk; wdata = mk_tag(bytes, TAG_USED); end
      S_AS2:  begin
        we = 1'b1; waddr = blk + WB + bytes; wdata = mk_tag(bytes, TAG_USED | TAG_FOOT);
      end
      S_AS3:  begin
        we = 1'b1; waddr = blk + TWO + bytes; wdata = mk_tag(tcur - bytes - TWO, TAG_FREE);
      end
      S_AS4:  begin
        we = 1'b1; waddr = blk + WB + tcur; wdata = mk_tag(tcur - bytes - TWO, TAG_FOOT);
      end
      S_AGF0: begin we = 1'b1; waddr = blk; wdata = mk_tag(tcur + grow, TAG_FREE); end
      S_AGF1: begin
        we = 1'b1; waddr = blk + WB + tcur + grow; wdata = mk_tag(tcur + grow, TAG_FOOT);
      end
      S_AGU0: begin we = 1'b1; waddr = heap_mark; wdata = mk_tag(grow - TWO, TAG_FREE); end
      S_AGU1: begin
        we = 1'b1; waddr = heap_mark + grow - WB; wdata = mk_tag(grow - TWO, TAG_FOOT);
      end
      S_FW0:  begin we = 1'b1; waddr = blk; wdata = mk_tag(total, TAG_FREE); end
      S_FW1:  begin we = 1'b1; waddr = blk + WB + total; wdata = mk_tag(total, TAG_FOOT); end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_CLR;
      clr_cnt       <= '0;
      heap_mark     <= PAGE;
      m_axis_tvalid <= 1'b0;
      ptr           <= '0;
    end else begin
      if (m_axis_tvalid && m_axis_tready && (state != S_DONE)) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_CLR: begin
          clr_cnt <= clr_cnt + 1'b1;
          if (clr_cnt == AW'(DEPTH - 1)) begin
            state <= S_INI0;
          end
        end
        S_INI0: state <= S_INI1;
        S_INI1: state <= S_IDLE;
        S_IDLE: begin
          if (s_axis_tvalid) begin
            act   <= s_axis_tdata[0];
            req   <= s_axis_tdata[16:1];
            off   <= s_axis_tdata[32:17];
            state <= S_STRT;
          end
        end
        S_STRT: begin
          stat <= STAT_DONE;
          res  <= '0;
          if (act == ACT_ALLOC) begin
            bytes <= rnd;
            grow  <= (pg == '0) ? PAGE : pg;
            blk   <= '0;
            state <= S_ALK;
          end else if ((off[WB_SH-1:0] != '0) || (off == '0) || (hdr >= heap_mark)) begin
            stat  <= STAT_BAD_PTR;
            state <= S_DONE;
          end else begin
            blk   <= hdr;
            ptr   <= hdr;
            state <= S_FH0;
          end
        end
        S_ALK: begin
          if (blk >= heap_mark) begin
            stat  <= STAT_NO_ROOM;
            state <= S_DONE;
          end else begin
            ptr   <= blk;
            state <= S_AWT;
          end
        end
        S_AWT: state <= S_AEV;
        S_AEV: begin
          tcur <= rsz;
          if (!rused && (rsz >= bytes + TWO)) begin
            state <= S_AS1;
          end else if (nxt >= heap_mark) begin
            if (heap_mark + grow > ARENA) begin
              stat  <= STAT_NO_ROOM;
              state <= S_DONE;
            end else if (!rused) begin
              state <= S_AGF0;
            end else begin
              state <= S_AGU0;
            end
          end else begin
            blk   <= nxt;
            state <= S_ALK;
          end
        end
        S_AS1: state <= S_AS2;
        S_AS2: state <= S_AS3;
        S_AS3: state <= S_AS4;
        S_AS4: begin
          res   <= 16'(blk + WB);
          state <= S_DONE;
        end
        S_AGF0: state <= S_AGF1;
        S_AGU0: state <= S_AGU1;
        S_AGF1, S_AGU1: begin
          heap_mark <= heap_mark + grow;
          state     <= S_ALK;
        end
        S_FH0: state <= S_FH1;
        S_FH1: begin
          tcur <= rsz;
          if (rfoot || (blk + WB + rsz >= heap_mark)) begin
            stat  <= STAT_BAD_PTR;
            state <= S_DONE;
          end else begin
            ptr   <= blk + WB + rsz;
            state <= S_FF0;
          end
        end
        S_FF0: state <= S_FF1;
        S_FF1: begin
          total <= tcur;
          if (!rfoot || (rsz != tcur)) begin
            stat  <= STAT_BAD_PTR;
            state <= S_DONE;
          end else if (blk + TWO + tcur < heap_mark) begin
            ptr   <= blk + TWO + tcur;
            state <= S_FN0;
          end else begin
            state <= S_FP;
          end
        end
        S_FN0: state <= S_FN1;
        S_FN1: begin
          if (!rused) begin
            total <= total + rsz + TWO;
          end
          state <= S_FP;
        end
        S_FP: begin
          if (blk == '0) begin
            state <= S_FW0;
          end else begin
            ptr   <= blk - WB;
            state <= S_FQ0;
          end
        end
        S_FQ0: state <= S_FQ1;
        S_FQ1: begin
          // previous footer gives the previous header
          if (blk >= TWO + rsz) begin
            ptr   <= blk - TWO - rsz;
            state <= S_FR0;
          end else begin
            state <= S_FW0;
          end
        end
        S_FR0: state <= S_FR1;
        S_FR1: begin
          if (!rused) begin
            total <= total + rsz + TWO;
            blk   <= ptr;
          end
          state <= S_FW0;
        end
        S_FW0: state <= S_FW1;
        S_FW1: state <= S_DONE;
        S_DONE: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            m_axis_tvalid <= 1'b1;
            out_status    <= stat;
            out_offset    <= res;
            state         <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
